// ===== hdl/pcq_pkg.sv =====
`default_nettype none
package pcq_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SWAP   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } pcq_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } pcq_status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } pcq_cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP_B,
        S_SWAP_A
    } pcq_state_t;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
    } pcq_pair_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] row_in;
        logic [7:0] col_in;
        logic [5:0] pos_a;
        logic [5:0] pos_b;
    } pcq_req_t;

    typedef struct packed {
        logic [7:0] row_out;
        logic [7:0] col_out;
        logic [5:0] length;
        logic [1:0] status;
    } pcq_res_t;

    typedef struct packed {
        pcq_cell_op_t op;
        pcq_pair_t    data;
    } pcq_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/positional_coordinate_queue_unit.sv =====
`default_nettype none
// Sequence: done pulses after the execute state, or for a swap after S_SWAP_B and S_SWAP_A.
// A new request is taken only while idle, not while busy; the swap reads both entries over the
// shared read bus, and busy stays high for the execute state and, for a swap, S_SWAP_B and S_SWAP_A.
// Reset clears the entry count and the control state; entry contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
module positional_coordinate_queue_unit #(
    parameter int DEPTH = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire pcq_pkg::pcq_req_t  request,
    output logic                    busy,
    output logic                    done,
    output pcq_pkg::pcq_res_t       result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    pcq_pkg::pcq_state_t state_reg, state_next;
    pcq_pkg::pcq_req_t   req_reg;
    logic [CW-1:0]       count_reg, count_next;
    pcq_pkg::pcq_pair_t  tmp_reg, tmp_next;
    pcq_pkg::pcq_res_t   res_reg, res_next;
    logic                done_reg, done_next;

    pcq_pkg::pcq_cell_ctrl_t cell_ctrl;
    logic [IW-1:0]           tgt;
    logic [IW-1:0]           rsel;
    pcq_pkg::pcq_pair_t      bus;
    pcq_pkg::pcq_pair_t      cell_pair [DEPTH];
    pcq_pkg::pcq_pair_t      cell_rd   [DEPTH];

    logic [PW-1:0] pa_ext, pb_ext, cnt_ext;
    logic          pa_ok, pb_ok;
    logic [IW-1:0] ia, ib;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            pcq_pkg::pcq_pair_t upper;
            if (gi == DEPTH - 1)
            begin : g_top
                assign upper = cell_pair[gi];
            end
            else
            begin : g_mid
                assign upper = cell_pair[gi + 1];
            end
            pcq_cell #(
                .IW  (IW),
                .IDX (gi)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .tgt     (tgt),
                .rsel    (rsel),
                .upper   (upper),
                .pair    (cell_pair[gi]),
                .rd_pair (cell_rd[gi])
            );
        end
    endgenerate

    // read bus: each cell drives zero unless selected
    always_comb
    begin
        bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            bus = bus | cell_rd[i];
        end
    end

    assign pa_ext  = PW'(req_reg.pos_a);
    assign pb_ext  = PW'(req_reg.pos_b);
    assign cnt_ext = PW'(count_reg);
    assign pa_ok   = (pa_ext != '0) && (pa_ext <= cnt_ext);
    assign pb_ok   = (pb_ext != '0) && (pb_ext <= cnt_ext);
    assign ia      = IW'(pa_ext - PW'(1));
    assign ib      = IW'(pb_ext - PW'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tmp_next       = tmp_reg;
        res_next       = res_reg;
        done_next      = 1'b0;
        cell_ctrl.op   = pcq_pkg::CELL_HOLD;
        cell_ctrl.data = '0;
        tgt            = '0;
        rsel           = '0;
        case (state_reg)
            pcq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = pcq_pkg::S_EXEC;
                end
            end
            pcq_pkg::S_EXEC:
            begin
                state_next       = pcq_pkg::S_IDLE;
                done_next        = 1'b1;
                res_next.row_out = '0;
                res_next.col_out = '0;
                res_next.status  = pcq_pkg::STAT_OK;
                rsel             = ia;
                case (req_reg.command)
                    pcq_pkg::CMD_APPEND:
                    begin
                        if (count_reg >= FULL_COUNT)
                        begin
                            res_next.status = pcq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cell_ctrl.op   = pcq_pkg::CELL_LOAD;
                            cell_ctrl.data = '{row: req_reg.row_in, col: req_reg.col_in};
                            tgt            = count_reg[IW-1:0];
                            count_next     = count_reg + CW'(1);
                        end
                    end
                    pcq_pkg::CMD_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = pcq_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            cell_ctrl.op = pcq_pkg::CELL_SHIFT;
                            tgt          = '0;
                            count_next   = count_reg - CW'(1);
                        end
                    end
                    pcq_pkg::CMD_DELETE:
                    begin
                        if (!pa_ok)
                        begin
                            res_next.status = pcq_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            cell_ctrl.op = pcq_pkg::CELL_SHIFT;
                            tgt          = ia;
                            count_next   = count_reg - CW'(1);
                        end
                    end
                    pcq_pkg::CMD_READ:
                    begin
                        if (!pa_ok)
                        begin
                            res_next.status = pcq_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            res_next.row_out = bus.row;
                            res_next.col_out = bus.col;
                        end
                    end
                    pcq_pkg::CMD_SWAP:
                    begin
                        if (!pa_ok || !pb_ok)
                        begin
                            res_next.status = pcq_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            // hold entry a, finish later
                            tmp_next   = bus;
                            done_next  = 1'b0;
                            state_next = pcq_pkg::S_SWAP_B;
                        end
                    end
                    default:
                    begin
                        res_next.status = pcq_pkg::STAT_OK;
                    end
                endcase
                res_next.length = 6'(count_next);
            end
            pcq_pkg::S_SWAP_B:
            begin
                // write old a into b while picking up old b
                rsel           = ib;
                tgt            = ib;
                cell_ctrl.op   = pcq_pkg::CELL_LOAD;
                cell_ctrl.data = tmp_reg;
                tmp_next       = bus;
                state_next     = pcq_pkg::S_SWAP_A;
            end
            pcq_pkg::S_SWAP_A:
            begin
                tgt              = ia;
                cell_ctrl.op     = pcq_pkg::CELL_LOAD;
                cell_ctrl.data   = tmp_reg;
                res_next.row_out = '0;
                res_next.col_out = '0;
                res_next.status  = pcq_pkg::STAT_OK;
                res_next.length  = 6'(count_reg);
                done_next        = 1'b1;
                state_next       = pcq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pcq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcq_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pcq_pkg::S_IDLE && start)
        begin
            req_reg <= request;
        end
        tmp_reg <= tmp_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != pcq_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ===== hdl/pcq_cell.sv =====
`default_nettype none
module pcq_cell #(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  wire                          clk,
    input  wire pcq_pkg::pcq_cell_ctrl_t ctrl,
    input  wire  [IW-1:0]                tgt,
    input  wire  [IW-1:0]                rsel,
    input  wire pcq_pkg::pcq_pair_t      upper,
    output pcq_pkg::pcq_pair_t           pair,
    output pcq_pkg::pcq_pair_t           rd_pair
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    pcq_pkg::pcq_pair_t pair_reg;
    pcq_pkg::pcq_pair_t pair_next;

    always_comb
    begin
        pair_next = pair_reg;
        case (ctrl.op)
            pcq_pkg::CELL_LOAD:
            begin
                if (MY_IDX == tgt)
                begin
                    pair_next = ctrl.data;
                end
            end
            pcq_pkg::CELL_SHIFT:
            begin
                // close the gap: every cell at or above the target takes its upper neighbor; the top cell keeps its own
                if (MY_IDX >= tgt)
                begin
                    pair_next = upper;
                end
            end
            default:
            begin
                pair_next = pair_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign pair    = pair_reg;
    assign rd_pair = (MY_IDX == rsel) ? pair_reg : '0;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH         = 32;
    localparam int          TAIL_CYCLES   = 8;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam logic [2:0]  CMD_LAST_CODE = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} cmd_mix_t;

    typedef struct {
        pcq_pkg::pcq_req_t req;
        int unsigned       gap;
        bit                drain;
    } cmd_slot_t;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    pcq_pkg::pcq_req_t request = '0;
    logic              busy;
    logic              done;
    pcq_pkg::pcq_res_t result;

    // queue contents as the block should hold them
    pcq_pkg::pcq_pair_t held_pairs [DEPTH];
    int unsigned        held_len = 0;

    pcq_pkg::pcq_res_t expected_results[$];
    cmd_slot_t         pending_cmds[$];
    int unsigned       plan_len = 0;

    cmd_slot_t   staged;
    bit          staged_valid = 0;
    int unsigned idle_left = 0;
    logic        drive_next;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    positional_coordinate_queue_unit #(.DEPTH(DEPTH)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit in_queue(int unsigned p);
        return p >= 1 && p <= held_len;
    endfunction

    // drop the entry at idx and pull the later ones forward
    function automatic void close_slot(int unsigned idx);
        for (int unsigned k = idx; k + 1 < held_len; k++)
            held_pairs[k] = held_pairs[k + 1];
        held_len--;
    endfunction

    function automatic pcq_pkg::pcq_res_t queue_outcome(pcq_pkg::pcq_req_t rq);
        pcq_pkg::pcq_res_t  res;
        pcq_pkg::pcq_pair_t tmp;
        int unsigned        a;
        int unsigned        b;
        res = '0;
        res.status = pcq_pkg::STAT_OK;
        a = rq.pos_a;
        b = rq.pos_b;
        case (rq.command)
            pcq_pkg::CMD_APPEND:
                if (held_len >= DEPTH)
                    res.status = pcq_pkg::STAT_FULL;
                else
                begin
                    held_pairs[held_len].row = rq.row_in;
                    held_pairs[held_len].col = rq.col_in;
                    held_len++;
                end
            pcq_pkg::CMD_REMOVE:
                if (held_len == 0)
                    res.status = pcq_pkg::STAT_RANGE;
                else
                    close_slot(0);
            pcq_pkg::CMD_SWAP:
                if (!in_queue(a) || !in_queue(b))
                    res.status = pcq_pkg::STAT_RANGE;
                else
                begin
                    tmp = held_pairs[a - 1];
                    held_pairs[a - 1] = held_pairs[b - 1];
                    held_pairs[b - 1] = tmp;
                end
            pcq_pkg::CMD_DELETE:
                if (!in_queue(a))
                    res.status = pcq_pkg::STAT_RANGE;
                else
                    close_slot(a - 1);
            pcq_pkg::CMD_READ:
                if (!in_queue(a))
                    res.status = pcq_pkg::STAT_RANGE;
                else
                begin
                    res.row_out = held_pairs[a - 1].row;
                    res.col_out = held_pairs[a - 1].col;
                end
            default: ;
        endcase
        res.length = 6'(held_len);
        return res;
    endfunction

    // queue one request and track the length it leaves behind
    task automatic plan_cmd(logic [2:0] cmd, logic [7:0] row, logic [7:0] col,
                            logic [5:0] pa, logic [5:0] pb, int unsigned gap, bit drain);
        cmd_slot_t slot;
        slot.req.command = cmd;
        slot.req.row_in  = row;
        slot.req.col_in  = col;
        slot.req.pos_a   = pa;
        slot.req.pos_b   = pb;
        slot.gap         = gap;
        slot.drain       = drain;
        pending_cmds.push_back(slot);
        case (cmd)
            pcq_pkg::CMD_APPEND: if (plan_len < DEPTH) plan_len++;
            pcq_pkg::CMD_REMOVE: if (plan_len > 0) plan_len--;
            pcq_pkg::CMD_DELETE: if (pa >= 1 && pa <= plan_len) plan_len--;
            default: ;
        endcase
    endtask

    function automatic logic [2:0] pick_command(cmd_mix_t mix);
        int unsigned r;
        int unsigned w_app;
        int unsigned w_rem;
        int unsigned w_swp;
        int unsigned w_del;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin w_app = 70; w_rem = 5;  w_swp = 8;  w_del = 5;  end
            MIX_DRAIN: begin w_app = 15; w_rem = 30; w_swp = 10; w_del = 30; end
            default:   begin w_app = 35; w_rem = 15; w_swp = 15; w_del = 15; end
        endcase
        if (r < 3)
            return 3'($urandom_range(pcq_pkg::CMD_READ + 1, CMD_LAST_CODE));
        r -= 3;
        if (r < w_app)
            return pcq_pkg::CMD_APPEND;
        r -= w_app;
        if (r < w_rem)
            return pcq_pkg::CMD_REMOVE;
        r -= w_rem;
        if (r < w_swp)
            return pcq_pkg::CMD_SWAP;
        r -= w_swp;
        if (r < w_del)
            return pcq_pkg::CMD_DELETE;
        return pcq_pkg::CMD_READ;
    endfunction

    // mostly a live position, now and then anything the field holds
    function automatic logic [5:0] pick_pos();
        if (plan_len > 0 && $urandom_range(0, 99) < 85)
            return 6'($urandom_range(1, plan_len));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic plan_random(cmd_mix_t mix, bit gappy, bit drain_first, int n);
        int unsigned gap;
        for (int i = 0; i < n; i++)
        begin
            gap = (gappy && $urandom_range(0, 99) < 25) ? $urandom_range(1, 15) : 0;
            plan_cmd(pick_command(mix), 8'($urandom), 8'($urandom), pick_pos(), pick_pos(),
                     gap, drain_first && i == 0);
        end
    endtask

    // driver: hold a request until accepted, then stage the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            drive_next = start;
            if (start && !busy)
            begin
                expected_results.push_back(queue_outcome(request));
                drive_next = 1'b0;
            end
            if (!drive_next)
            begin
                if (!staged_valid && pending_cmds.size() > 0)
                begin
                    staged = pending_cmds.pop_front();
                    staged_valid = 1;
                    idle_left = staged.gap;
                end
                if (staged_valid)
                begin
                    if (idle_left > 0)
                        idle_left--;
                    else if (!(staged.drain && expected_results.size() > 0))
                    begin
                        request <= staged.req;
                        drive_next = 1'b1;
                        staged_valid = 0;
                    end
                end
            end
            start <= drive_next;
        end
    end

    // monitor: every strobe is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_error("result with no request outstanding");
            else
            begin
                pcq_pkg::pcq_res_t want;
                want = expected_results.pop_front();
                if (result.row_out !== want.row_out)
                    report_error($sformatf("row_out got %0d expected %0d",
                                           result.row_out, want.row_out));
                if (result.col_out !== want.col_out)
                    report_error($sformatf("col_out got %0d expected %0d",
                                           result.col_out, want.col_out));
                if (result.length !== want.length)
                    report_error($sformatf("length got %0d expected %0d",
                                           result.length, want.length));
                if (result.status !== want.status)
                    report_error($sformatf("status got %0d expected %0d",
                                           result.status, want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        // empty queue
        plan_cmd(pcq_pkg::CMD_REMOVE, 8'h00, 8'h00, 6'd1, 6'd1, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd1, 6'd1, 0, 0);
        plan_cmd(pcq_pkg::CMD_SWAP,   8'h00, 8'h00, 6'd1, 6'd1, 0, 0);
        plan_cmd(pcq_pkg::CMD_DELETE, 8'h00, 8'h00, 6'd1, 6'd1, 0, 0);
        // coordinate extremes
        plan_cmd(pcq_pkg::CMD_APPEND, 8'h00, 8'hFF, 6'd0, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_APPEND, 8'hFF, 8'h00, 6'd63, 6'd63, 0, 0);
        plan_cmd(pcq_pkg::CMD_APPEND, 8'hA5, 8'h5A, 6'd21, 6'd42, 0, 0);
        plan_cmd(pcq_pkg::CMD_APPEND, 8'hFF, 8'hFF, 6'd0, 6'd0, 0, 0);
        // reads at and past both ends
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd1, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd4, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd0, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd5, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd63, 6'd0, 0, 0);
        // swaps: ends, with itself, either slot out of range
        plan_cmd(pcq_pkg::CMD_SWAP,   8'h00, 8'h00, 6'd1, 6'd4, 0, 0);
        plan_cmd(pcq_pkg::CMD_SWAP,   8'h00, 8'h00, 6'd2, 6'd2, 0, 0);
        plan_cmd(pcq_pkg::CMD_SWAP,   8'h00, 8'h00, 6'd3, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_SWAP,   8'h00, 8'h00, 6'd5, 6'd1, 0, 0);
        // delete from the middle, then past the new tail
        plan_cmd(pcq_pkg::CMD_DELETE, 8'h00, 8'h00, 6'd2, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_DELETE, 8'h00, 8'h00, 6'd4, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd2, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_READ,   8'h00, 8'h00, 6'd3, 6'd0, 0, 0);
        for (int c = pcq_pkg::CMD_READ + 1; c <= CMD_LAST_CODE; c++)
            plan_cmd(3'(c), 8'hFF, 8'hFF, 6'd1, 6'd1, 0, 0);
        plan_cmd(pcq_pkg::CMD_REMOVE, 8'h00, 8'h00, 6'd0, 6'd0, 0, 0);
        plan_cmd(pcq_pkg::CMD_APPEND, 8'h00, 8'h00, 6'd0, 6'd0, 0, 0);

        plan_random(MIX_FILL,  1, 1, 120);
        plan_random(MIX_EVEN,  1, 0, 150);
        plan_random(MIX_DRAIN, 0, 1, 120);
        plan_random(MIX_FILL,  0, 0, 100);
        plan_random(MIX_EVEN,  1, 1, 200);
        plan_random(MIX_DRAIN, 1, 0, 150);
        plan_random(MIX_FILL,  1, 1, 150);
        plan_random(MIX_EVEN,  0, 0, 150);
        plan_random(MIX_DRAIN, 1, 1, 150);
        // closing stretch runs back to back
        plan_random(MIX_EVEN,  0, 1, 200);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || staged_valid || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/pcq_pkg.sv
hdl/pcq_cell.sv
hdl/positional_coordinate_queue_unit.sv
tb/sv/tb.sv
